// File: hw/rtl/aic_pkg.sv
// shared types and constants of the analog input conditioner
package aic_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int SCALED_W    = 15;
   localparam int RANGE_W     = 16;
   localparam int PCT_W       = 21;
   localparam int DIFF_W      = RANGE_W + 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int LEVEL_IN_W = 4;
   localparam int LEVEL_CMP_W = 6;

   localparam logic [CSR_ADDR_W-1:0] CSR_FILTER_LEVEL = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ON_THRESHOLD = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_HYSTERESIS   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_PERCENT_MODE = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_RANGE_LOW    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_RANGE_HIGH   = 3'd5;

   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] PCT_SRC_RAW = 2'd0;
   localparam logic [MODE_W-1:0] PCT_SRC_MV  = 2'd1;
   localparam logic [MODE_W-1:0] PCT_SRC_MA  = 2'd2;

   localparam int FULL_SCALE = 4095;
   localparam int MV_SCALE   = 31390;
   localparam int MA_SCALE   = 21997;

   // reciprocal scaling, exact floor for every 12-bit value
   localparam int SCALE_FRAC   = 24;
   localparam int SCALE_MULT_W = 27;
   localparam int SCALE_PROD_W = SAMPLE_BITS + SCALE_MULT_W;
   localparam longint unsigned MV_MULT =
      ((longint'(MV_SCALE) << SCALE_FRAC) + FULL_SCALE - 1) / FULL_SCALE;
   localparam longint unsigned MA_MULT =
      ((longint'(MA_SCALE) << SCALE_FRAC) + FULL_SCALE - 1) / FULL_SCALE;

   localparam int PCT_FACTOR = 10000;
   localparam int PCT_LIMIT  = 1000000;
   localparam int PCT_MAG_W  = 20;

   localparam int DIV_NUM_W = 30;
   localparam int DIV_DEN_W = 16;
   localparam int DIV_CNT_W = 5;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic       step;
      logic       preset;
      sample_type preset_value;
   } cell_ctrl_type;

endpackage

// File: hw/rtl/analog_input_conditioner.sv
// analog input conditioner top level: filter chain, scaling, comparator, percent
// a request passes the states MUL, SRC, SCALE, DIV (the 30-step percent divider)
// and DONE before rsp_valid, skipping DIV when the range is empty; DONE holds until
// the output register is free, and one transaction is in flight at a time
// a finished response waits in the output register while the next request is taken
// reset: synchronous; control and CSR registers go to defaults, filter stages stay unset
module analog_input_conditioner #(
   parameter int MAX_STAGES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [aic_pkg::SAMPLE_BITS-1:0]  req_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [aic_pkg::SAMPLE_BITS-1:0]  rsp_filtered_value,
   output logic [aic_pkg::SCALED_W-1:0]     rsp_voltage_mv,
   output logic [aic_pkg::SCALED_W-1:0]     rsp_current_ma,
   output logic                             rsp_discrete_on,
   output logic [aic_pkg::PCT_W-1:0]        rsp_percent_x100,
   output logic                             rsp_range_error,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [aic_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [aic_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import aic_pkg::*;

   localparam int LVL_W = $clog2(MAX_STAGES + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_SRC   = 3'd2;
   localparam logic [2:0] ST_SCALE = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]               state_ff, state_in;

   logic [LVL_W-1:0]         level_ff;
   logic [SAMPLE_BITS-1:0]   on_thr_ff;
   logic [SAMPLE_BITS-1:0]   hyst_ff;
   logic [MODE_W-1:0]        mode_ff;
   logic [RANGE_W-1:0]       range_lo_ff;
   logic [RANGE_W-1:0]       range_hi_ff;

   sample_type               cur_ff, cur_in;
   logic                     disc_ff;

   logic [SCALED_W-1:0]      mv_ff, ma_ff;
   logic signed [DIFF_W-1:0] diff_ff, den_ff;
   logic                     neg_ff, err_ff;

   logic                     rsp_valid_ff;
   sample_type               out_value_ff;
   logic [SCALED_W-1:0]      out_mv_ff, out_ma_ff;
   logic                     out_disc_ff;
   logic [PCT_W-1:0]         out_pct_ff;
   logic                     out_err_ff;

   logic                     req_accept;
   logic                     lvl_wr;
   logic [LEVEL_CMP_W-1:0]   lvl_wr_raw;
   logic [LEVEL_CMP_W-1:0]   lvl_wr_sat;
   logic [LVL_W-1:0]         level_sel;

   cell_ctrl_type            cell_ctrl;
   sample_type               stage_q [MAX_STAGES];
   sample_type               avg_q   [MAX_STAGES];

   logic [SCALE_PROD_W-1:0]  mv_prod, ma_prod;
   logic signed [SAMPLE_BITS:0] off_point, cur_s;
   logic [SCALED_W-1:0]      src;
   logic [DIFF_W-1:0]        diff_neg, den_neg;
   logic [DIV_DEN_W-1:0]     diff_mag, den_mag;
   logic [DIV_NUM_W-1:0]     num;
   logic                     div_start, div_done;
   logic [DIV_NUM_W-1:0]     quotient;
   logic [PCT_MAG_W-1:0]     pct_mag;
   logic [PCT_W-1:0]         pct;
   logic                     out_load;

   assign req_ready  = !reset && (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = !reset;

   // filter level write saturates at the stage count
   always_comb begin
      lvl_wr     = csr_valid && csr_ready && (csr_addr == CSR_FILTER_LEVEL);
      lvl_wr_raw = LEVEL_CMP_W'(csr_wdata[LEVEL_IN_W-1:0]);
      lvl_wr_sat = (lvl_wr_raw > LEVEL_CMP_W'(MAX_STAGES)) ?
                   LEVEL_CMP_W'(MAX_STAGES) : lvl_wr_raw;
      level_sel  = lvl_wr ? LVL_W'(lvl_wr_sat) : level_ff;
   end

   always_comb begin
      cell_ctrl.step         = req_accept;
      cell_ctrl.preset       = lvl_wr;
      cell_ctrl.preset_value = cur_ff;
   end

   for (genvar i = 0; i < MAX_STAGES; i++) begin : g_cell
      sample_type right_value;
      if (i == MAX_STAGES - 1) begin : g_tail
         assign right_value = req_sample;
      end else begin : g_body
         assign right_value = stage_q[i+1];
      end
      aic_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .active      (LVL_W'(i) < level_sel),
         .last        (LVL_W'(i + 1) == level_sel),
         .sample      (req_sample),
         .right_value (right_value),
         .stage_value (stage_q[i]),
         .avg_value   (avg_q[i])
      );
   end

   assign cur_in = (level_ff == '0) ? req_sample : avg_q[0];

   // scaling, comparator and percent datapath
   always_comb begin
      mv_prod   = SCALE_PROD_W'(cur_ff) * SCALE_PROD_W'(MV_MULT);
      ma_prod   = SCALE_PROD_W'(cur_ff) * SCALE_PROD_W'(MA_MULT);
      off_point = $signed({1'b0, on_thr_ff}) - $signed({1'b0, hyst_ff});
      cur_s     = $signed({1'b0, cur_ff});
      case (mode_ff)
         PCT_SRC_RAW: src = SCALED_W'(cur_ff);
         PCT_SRC_MV:  src = mv_ff;
         PCT_SRC_MA:  src = ma_ff;
         default:     src = '0;
      endcase
      diff_neg  = -diff_ff;
      den_neg   = -den_ff;
      diff_mag  = diff_ff[DIFF_W-1] ? diff_neg[DIV_DEN_W-1:0] : diff_ff[DIV_DEN_W-1:0];
      den_mag   = den_ff[DIFF_W-1] ? den_neg[DIV_DEN_W-1:0] : den_ff[DIV_DEN_W-1:0];
      num       = DIV_NUM_W'(diff_mag) * DIV_NUM_W'(PCT_FACTOR);
      div_start = (state_ff == ST_SCALE) && (den_ff != '0);
      pct_mag   = (quotient > DIV_NUM_W'(PCT_LIMIT)) ?
                  PCT_MAG_W'(PCT_LIMIT) : quotient[PCT_MAG_W-1:0];
      if (err_ff) begin
         pct = '0;
      end else if (neg_ff) begin
         pct = -PCT_W'(pct_mag);
      end else begin
         pct = PCT_W'(pct_mag);
      end
      out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   aic_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num),
      .den      (den_mag),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_accept) state_in = ST_MUL;
         ST_MUL:   state_in = ST_SRC;
         ST_SRC:   state_in = ST_SCALE;
         ST_SCALE: state_in = (den_ff == '0) ? ST_DONE : ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_DONE;
         ST_DONE:  if (out_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= '0;
         on_thr_ff    <= SAMPLE_BITS'(2048);
         hyst_ff      <= SAMPLE_BITS'(200);
         mode_ff      <= PCT_SRC_RAW;
         range_lo_ff  <= '0;
         range_hi_ff  <= RANGE_W'(4095);
         cur_ff       <= '0;
         disc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_addr)
               CSR_FILTER_LEVEL: level_ff    <= LVL_W'(lvl_wr_sat);
               CSR_ON_THRESHOLD: on_thr_ff   <= csr_wdata[SAMPLE_BITS-1:0];
               CSR_HYSTERESIS:   hyst_ff     <= csr_wdata[SAMPLE_BITS-1:0];
               CSR_PERCENT_MODE: mode_ff     <= csr_wdata[MODE_W-1:0];
               CSR_RANGE_LOW:    range_lo_ff <= csr_wdata[RANGE_W-1:0];
               CSR_RANGE_HIGH:   range_hi_ff <= csr_wdata[RANGE_W-1:0];
               default:          ;
            endcase
         end
         if (req_accept) begin
            cur_ff <= cur_in;
         end
         if (state_ff == ST_MUL) begin
            if (cur_ff >= on_thr_ff) begin
               disc_ff <= 1'b1;
            end else if (cur_s < off_point) begin
               disc_ff <= 1'b0;
            end
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         mv_ff <= mv_prod[SCALE_FRAC +: SCALED_W];
         ma_ff <= ma_prod[SCALE_FRAC +: SCALED_W];
      end
      if (state_ff == ST_SRC) begin
         diff_ff <= $signed({2'b00, src}) - $signed({range_lo_ff[RANGE_W-1], range_lo_ff});
         den_ff  <= $signed({range_hi_ff[RANGE_W-1], range_hi_ff})
                    - $signed({range_lo_ff[RANGE_W-1], range_lo_ff});
      end
      if (state_ff == ST_SCALE) begin
         neg_ff <= diff_ff[DIFF_W-1] ^ den_ff[DIFF_W-1];
         err_ff <= den_ff == '0;
      end
      if (out_load) begin
         out_value_ff <= cur_ff;
         out_mv_ff    <= mv_ff;
         out_ma_ff    <= ma_ff;
         out_disc_ff  <= disc_ff;
         out_pct_ff   <= pct;
         out_err_ff   <= err_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = out_value_ff;
   assign rsp_voltage_mv     = out_mv_ff;
   assign rsp_current_ma     = out_ma_ff;
   assign rsp_discrete_on    = out_disc_ff;
   assign rsp_percent_x100   = out_pct_ff;
   assign rsp_range_error    = out_err_ff;

   a_accept_to_mul: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_MUL)
      else $error("accepted request did not start scaling");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the wait state");

   a_err_zero_pct: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_err_ff |-> out_pct_ff == '0)
      else $error("empty range with nonzero percent");

   a_pct_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($signed(out_pct_ff) <= $signed(PCT_W'(PCT_LIMIT)))
                    && ($signed(out_pct_ff) >= -$signed(PCT_W'(PCT_LIMIT))))
      else $error("percent outside saturation limit");

endmodule

// File: hw/rtl/aic_cell.sv
// one averaging stage of the filter chain
module aic_cell (
   input  logic                   clock,
   input  aic_pkg::cell_ctrl_type ctrl,
   input  logic                   active,
   input  logic                   last,
   input  aic_pkg::sample_type    sample,
   input  aic_pkg::sample_type    right_value,
   output aic_pkg::sample_type    stage_value,
   output aic_pkg::sample_type    avg_value
);
   import aic_pkg::*;

   sample_type             stage_ff;
   sample_type             stage_in;
   sample_type             nbr;
   logic [SAMPLE_BITS:0]   sum;

   always_comb begin
      nbr       = last ? sample : right_value;
      sum       = {1'b0, stage_ff} + {1'b0, nbr};
      avg_value = sum[SAMPLE_BITS:1];
      stage_in  = stage_ff;
      if (active && ctrl.preset) begin
         stage_in = ctrl.preset_value;
      end else if (active && ctrl.step) begin
         stage_in = avg_value;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign stage_value = stage_ff;

endmodule

// File: hw/rtl/aic_divider.sv
// radix-2 restoring divider for the percent quotient
module aic_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [aic_pkg::DIV_NUM_W-1:0]   num,
   input  logic [aic_pkg::DIV_DEN_W-1:0]   den,
   output logic                            done,
   output logic [aic_pkg::DIV_NUM_W-1:0]   quotient
);
   import aic_pkg::*;

   logic                   busy_ff;
   logic                   done_ff;
   logic [DIV_CNT_W-1:0]   cnt_ff;
   logic [DIV_NUM_W-1:0]   quo_ff;
   logic [DIV_DEN_W-1:0]   rem_ff;
   logic [DIV_DEN_W-1:0]   den_ff;
   logic [DIV_DEN_W:0]     trial;
   logic [DIV_DEN_W:0]     trial_sub;
   logic                   ge;

   always_comb begin
      trial     = {rem_ff, quo_ff[DIV_NUM_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      ge        = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_NUM_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         quo_ff <= {quo_ff[DIV_NUM_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
